@@ rtl/jssd_pkg.sv @@
// ----------------------------------------------------------------------------
// jssd_pkg
// Shared types and constants of the job shop schedule decoder.
// ----------------------------------------------------------------------------
package jssd_pkg;

  localparam int unsigned MaxJobsDef     = 16;
  localparam int unsigned MaxMachinesDef = 16;
  localparam int unsigned MaxSlotsDef    = 32;
  localparam int unsigned TimeBitsDef    = 16;

  localparam int unsigned IdBits   = 4;
  localparam int unsigned ProcBits = 12;
  localparam int unsigned OutBits  = 16;

  localparam logic ModeSemi   = 1'b0;
  localparam logic ModeActive = 1'b1;

  typedef struct packed {
    logic [IdBits-1:0]   job_id;
    logic [IdBits-1:0]   machine_id;
    logic [ProcBits-1:0] op_time;
    logic                first_op;
    logic                last_op;
  } req_t;

  typedef struct packed {
    logic [OutBits-1:0] start_time;
    logic [OutBits-1:0] end_time;
    logic [OutBits-1:0] makespan;
    logic               overflow;
    logic               is_last;
  } rsp_t;

endpackage

@@ rtl/jssd_cell.sv @@
// ----------------------------------------------------------------------------
// jssd_cell
// One slot of a machine's busy list: holds one interval and hands its start
// and end to the next cell. On insert it shifts right.
// ----------------------------------------------------------------------------
module jssd_cell #(
  parameter int unsigned TIME_BITS = jssd_pkg::TimeBitsDef
) (
  input  logic                 clk,
  input  logic                 load,       // load interval from memory row
  input  logic [TIME_BITS-1:0] load_start,
  input  logic [TIME_BITS-1:0] load_end,
  input  logic                 shift,      // take neighbor interval
  input  logic                 put,        // take new interval
  input  logic [TIME_BITS-1:0] left_start,
  input  logic [TIME_BITS-1:0] left_end,
  input  logic [TIME_BITS-1:0] new_start,
  input  logic [TIME_BITS-1:0] new_end,
  output logic [TIME_BITS-1:0] cur_start,
  output logic [TIME_BITS-1:0] cur_end
);
  logic [TIME_BITS-1:0] s, e;

  always_ff @(posedge clk) begin
    if (load) begin
      s <= load_start;
      e <= load_end;
    end else if (put) begin
      s <= new_start;
      e <= new_end;
    end else if (shift) begin
      s <= left_start;
      e <= left_end;
    end
  end

  assign cur_start = s;
  assign cur_end   = e;
endmodule

@@ rtl/jssd_ram.sv @@
// ----------------------------------------------------------------------------
// jssd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module jssd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/job_shop_schedule_decoder_top.sv @@
// ----------------------------------------------------------------------------
// job_shop_schedule_decoder_top
// Schedule decoder: places one operation per request, returns start/end.
// ----------------------------------------------------------------------------
// A request passes S_IDLE, S_RD, S_LOAD, S_CALC and S_DONE. In active mode,
// for a machine in the table, it also passes the gap scan (S_SCAN), which
// steps through the listed intervals, and the insert position search (S_INS),
// which steps past the intervals that start before the new one; in semi-active
// mode or for a machine outside the table it skips both. The busy list of the
// addressed machine is loaded from a row-wide RAM into a chain of MAX_SLOTS
// cells, the chain shifts to insert the new interval, and the row is written
// back. A first_op request clears the small tables in its accept cycle. The
// input side stays closed until the result has been taken.
module job_shop_schedule_decoder_top #(
  parameter int unsigned MAX_JOBS     = jssd_pkg::MaxJobsDef,
  parameter int unsigned MAX_MACHINES = jssd_pkg::MaxMachinesDef,
  parameter int unsigned MAX_SLOTS    = jssd_pkg::MaxSlotsDef,
  parameter int unsigned TIME_BITS    = jssd_pkg::TimeBitsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jssd_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output jssd_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);
  import jssd_pkg::*;

  localparam int unsigned MB  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned JB  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned SB  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CB  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned RW  = 2 * TIME_BITS * MAX_SLOTS;
  localparam int unsigned RD  = (MAX_MACHINES > 1) ? MAX_MACHINES : 2;
  localparam int unsigned SW  = ((TIME_BITS > ProcBits) ? TIME_BITS : ProcBits) + 1;
  localparam logic [TIME_BITS-1:0] TMax = '1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_INS   = 7'b0100000,
    S_DONE  = 7'b1000000
  } st_t;

  st_t  st;
  logic mode;
  req_t rq;
  logic [TIME_BITS-1:0] job_finish    [MAX_JOBS];
  logic [TIME_BITS-1:0] machine_ready [MAX_MACHINES];
  logic [CB-1:0]        busy_count    [MAX_MACHINES];
  logic [TIME_BITS-1:0] mkspan;
  logic [TIME_BITS-1:0] earliest, gap_floor, start, fin;
  logic [CB-1:0]        k, n, idx;
  logic                 placed, ovf, job_ok, mach_ok;
  logic [SW-1:0]        sum;
  logic                 idx_step, ins_go;

  logic [RW-1:0] rd_row, wr_row;
  logic          ram_we;
  logic [MB-1:0] ram_addr;

  logic [TIME_BITS-1:0] cs [MAX_SLOTS];
  logic [TIME_BITS-1:0] ce [MAX_SLOTS];

  assign job_ok  = 32'(rq.job_id) < MAX_JOBS;
  assign mach_ok = 32'(rq.machine_id) < MAX_MACHINES;
  assign ram_addr = MB'(rq.machine_id);

  // insert position search steps while the slot starts before the new one;
  // the chain shifts on the last cycle of the search
  assign idx_step = (st == S_INS) && n < CB'(MAX_SLOTS) && idx < n
                    && cs[idx[SB-1:0]] < start;
  assign ins_go   = (st == S_INS) && !idx_step && n < CB'(MAX_SLOTS);

  jssd_ram #(.WIDTH(RW), .DEPTH(RD)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wr_row), .rdata(rd_row)
  );

  // cell k shifts when k > idx and k <= n; cell idx takes the new interval
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    logic [TIME_BITS-1:0] ls, le;
    if (g == 0) begin : g_h
      assign ls = '0;
      assign le = '0;
    end else begin : g_b
      assign ls = cs[g-1];
      assign le = ce[g-1];
    end
    jssd_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk(clk), .load(st == S_LOAD),
      .load_start(rd_row[(2*g)*TIME_BITS +: TIME_BITS]),
      .load_end(rd_row[(2*g+1)*TIME_BITS +: TIME_BITS]),
      .shift(ins_go && CB'(g) > idx && CB'(g) <= n),
      .put(ins_go && CB'(g) == idx),
      .left_start(ls), .left_end(le), .new_start(start), .new_end(fin),
      .cur_start(cs[g]), .cur_end(ce[g])
    );
    assign wr_row[(2*g)*TIME_BITS +: TIME_BITS]   = cs[g];
    assign wr_row[(2*g+1)*TIME_BITS +: TIME_BITS] = ce[g];
  end

  logic [TIME_BITS-1:0] cand, head_s;
  assign cand   = (earliest > gap_floor) ? earliest : gap_floor;
  assign head_s = cs[k[SB-1:0]];
  assign sum    = SW'(start) + SW'(rq.op_time);

  assign in_ready = (st == S_IDLE) && !out_valid;
  assign ram_we   = (st == S_DONE) && mode == ModeActive && mach_ok && n < CB'(MAX_SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      mode      <= ModeActive;
      out_valid <= 1'b0;
      mkspan    <= '0;
      for (int i = 0; i < MAX_JOBS; i++) job_finish[i] <= '0;
      for (int i = 0; i < MAX_MACHINES; i++) begin
        machine_ready[i] <= '0;
        busy_count[i]    <= '0;
      end
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (in_valid && in_ready) begin
          rq <= in_data;
          if (in_data.first_op) begin
            mkspan <= '0;
            for (int i = 0; i < MAX_JOBS; i++) job_finish[i] <= '0;
            for (int i = 0; i < MAX_MACHINES; i++) begin
              machine_ready[i] <= '0;
              busy_count[i]    <= '0;
            end
          end
          st <= S_RD;
        end
        S_RD: begin
          earliest  <= job_ok ? job_finish[JB'(rq.job_id)] : '0;
          n         <= mach_ok ? busy_count[ram_addr] : '0;
          start     <= '0;
          gap_floor <= '0;
          k         <= '0;
          placed    <= 1'b0;
          st        <= S_LOAD;
        end
        S_LOAD: begin
          start <= earliest;
          if (mach_ok && mode == ModeSemi) begin
            if (machine_ready[ram_addr] > earliest) start <= machine_ready[ram_addr];
            st <= S_CALC;
          end else if (mach_ok) begin
            st <= S_SCAN;
          end else begin
            st <= S_CALC;
          end
        end
        S_SCAN: begin
          if (k < n && !placed) begin
            if (SW'(cand) + SW'(rq.op_time) <= SW'(head_s)) begin
              start  <= cand;
              placed <= 1'b1;
            end else begin
              gap_floor <= ce[k[SB-1:0]];
              k         <= k + 1'b1;
            end
          end else begin
            if (!placed) start <= cand;
            st <= S_CALC;
          end
        end
        S_CALC: begin
          ovf <= sum > SW'(TMax);
          fin <= (sum > SW'(TMax)) ? TMax : sum[TIME_BITS-1:0];
          idx <= '0;
          st  <= (mach_ok && mode == ModeActive) ? S_INS : S_DONE;
          // idx search, one slot a cycle, done in S_INS
        end
        S_INS: begin
          if (idx_step) begin
            idx <= idx + 1'b1;
          end else begin
            st <= S_DONE;  // cells insert on this edge unless the list is full
          end
        end
        S_DONE: begin
          if (mach_ok) begin
            if (mode == ModeSemi) begin
              machine_ready[ram_addr] <= fin;
            end else begin
              if (n >= CB'(MAX_SLOTS)) ovf <= 1'b1;
              else busy_count[ram_addr] <= n + 1'b1;
              if (fin > machine_ready[ram_addr]) machine_ready[ram_addr] <= fin;
            end
          end
          if (job_ok) job_finish[JB'(rq.job_id)] <= fin;
          if (fin > mkspan) mkspan <= fin;
          out_valid <= 1'b1;
          st        <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  logic [TIME_BITS-1:0] mk_out;
  assign mk_out = (fin > mkspan) ? fin : mkspan;
  logic ovf_out;
  assign ovf_out = ovf;

  always_ff @(posedge clk) begin
    if (st == S_DONE) begin
      out_data.start_time <= OutBits'(start);
      out_data.end_time   <= OutBits'(fin);
      out_data.makespan   <= OutBits'(mk_out);
      out_data.overflow   <= ovf_out || (mach_ok && mode == ModeActive
                                         && n >= CB'(MAX_SLOTS));
      out_data.is_last    <= rq.last_op;
    end
  end
endmodule

@@ rtl/jssd_checker.sv @@
// ----------------------------------------------------------------------------
// jssd_checker
// Port-level checks of the schedule decoder, bound to the top level.
// ----------------------------------------------------------------------------
module jssd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input jssd_pkg::rsp_t out_data
);
  import jssd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_end_ge_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.end_time >= out_data.start_time)
    else $error("end before start");

  a_mk_ge_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.makespan >= out_data.end_time)
    else $error("makespan below end");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");
endmodule

bind job_shop_schedule_decoder_top jssd_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
